// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent assertion on a clock, switched off while the reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion on a clock that is checked in every cycle.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

// ===== sv/mdus_pkg.sv =====
// Package with the types and constants of the minimum distance selector.
`timescale 1ns / 1ps

package mdus_pkg;

  // Value and configuration widths.
  localparam int unsigned VAL_W         = 24;
  localparam int unsigned CFG_W         = 24;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned MAX_KEPT_DEF  = 64;

  // Reset value of the circular period.
  localparam logic [VAL_W-1:0] WRAP_PERIOD_RST = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST    = 2'd0,
    CFG_WRAP_EN     = 2'd1,
    CFG_WRAP_PERIOD = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_WAIT   = 2'd2,
    ST_FINISH = 2'd3
  } mdus_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new transaction
    logic issue;   // read the next stored value
    logic finish;  // decide, store and report
  } mdus_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every stored value has been read
  } mdus_status_t;

endpackage

// ===== sv/mdus_ctrl.sv =====
// Controller state machine of the minimum distance selector.
`timescale 1ns / 1ps

module mdus_ctrl import mdus_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  mdus_status_t status_i,
  output mdus_cmd_t    cmd_o
);

  mdus_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. The scan issues one read per cycle; the wait
  // state lets the last compare leave the two-stage compare pipeline.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_WAIT;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/mdus_datapath.sv =====
// Datapath of the minimum distance selector: registers, table memory, compare pipe.
`timescale 1ns / 1ps

module mdus_datapath import mdus_pkg::*; #(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [VAL_W-1:0]     candidate_value_i,
  input  logic                 group_start_i,
  input  mdus_cmd_t            cmd_i,
  output mdus_status_t         status_o,
  output logic                 result_valid_o,
  output logic                 kept_o,
  output logic                 table_overflow_o
);

  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);
  localparam int unsigned IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  // Configuration registers.
  logic [VAL_W-1:0] min_dist_q;
  logic             wrap_en_q;
  logic [VAL_W-1:0] wrap_period_q;

  // Per-transaction registers.
  logic [VAL_W-1:0]        cand_q;
  logic signed [VAL_W:0]   limit_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        ptr_q;
  logic                    rd_vld_q, dist_vld_q;
  logic [VAL_W-1:0]        rdata_q;
  logic [VAL_W-1:0]        dist_q, dist_d;
  logic                    hit_q;
  logic                    close;
  logic                    kept, store;
  logic                    result_valid_q, kept_q, overflow_q;

  // Table of stored values.
  logic [VAL_W-1:0] mem_q [MAX_KEPT];

  // Configuration writes; an index outside the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q    <= '0;
      wrap_en_q     <= 1'b0;
      wrap_period_q <= WRAP_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MIN_DIST:    min_dist_q    <= cfg_wdata_i[VAL_W-1:0];
        CFG_WRAP_EN:     wrap_en_q     <= cfg_wdata_i[0];
        CFG_WRAP_PERIOD: wrap_period_q <= cfg_wdata_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Candidate and wrap limit, captured when a transaction is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cand_q  <= candidate_value_i;
      limit_q <= $signed({1'b0, wrap_period_q}) - $signed({1'b0, min_dist_q});
    end
  end

  // Decision at the end of the scan.
  assign kept  = !hit_q;
  assign store = kept && (count_q < CNT_W'(MAX_KEPT));

  // Fill count: cleared by a group start, advanced when a value is stored.
  always_comb begin
    count_d = count_q;
    if (cmd_i.load && group_start_i) begin
      count_d = '0;
    end else if (cmd_i.finish && store) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  // Read pointer, compare pipeline valids, and the accumulated hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      count_q    <= count_d;
      rd_vld_q   <= cmd_i.issue;
      dist_vld_q <= rd_vld_q;
      if (cmd_i.load) begin
        ptr_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
        if (dist_vld_q && close) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.scan_done = (ptr_q == count_q);

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && store) begin
      mem_q[count_q[IDX_W-1:0]] <= cand_q;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[ptr_q[IDX_W-1:0]];
    end
  end

  // Absolute difference: both orders are formed and the positive one is kept.
  always_comb begin
    logic [VAL_W:0] diff_ab;
    logic [VAL_W:0] diff_ba;
    diff_ab = {1'b0, cand_q} - {1'b0, rdata_q};
    diff_ba = {1'b0, rdata_q} - {1'b0, cand_q};
    dist_d  = diff_ab[VAL_W] ? diff_ba[VAL_W-1:0] : diff_ab[VAL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      dist_q <= dist_d;
    end
  end

  // Too close when the distance is below the minimum, or in circular mode
  // when it exceeds the period minus the minimum (the wrapped distance is
  // then below the minimum).
  assign close = ({1'b0, dist_q} < {1'b0, min_dist_q}) ||
                 (wrap_en_q && ($signed({1'b0, dist_q}) > limit_q));

  // Result registers, shown for one cycle after the decision.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      kept_q     <= kept;
      overflow_q <= kept && !store;
    end
  end

  assign result_valid_o   = result_valid_q;
  assign kept_o           = kept_q;
  assign table_overflow_o = overflow_q;

endmodule

// ===== sv/min_distance_unique_selector.sv =====
// Top level of the minimum distance selector: controller, datapath and checks.
// Sequence: once a transaction is accepted, the values stored in the group are scanned, one
// table entry read per cycle; a wait state and a finish state follow, and result_valid_o
// is registered from the finish command. A new transaction waits until busy is low again.
// Reset clears the fill count, the controller and the configuration registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_distance_unique_selector import mdus_pkg::*; #(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [VAL_W-1:0]     candidate_value_i,
  input  logic                 group_start_i,
  output logic                 result_valid_o,
  output logic                 kept_o,
  output logic                 table_overflow_o
);

  mdus_cmd_t    cmd;
  mdus_status_t status;

  // Controller.
  mdus_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath.
  mdus_datapath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .candidate_value_i (candidate_value_i),
    .group_start_i     (group_start_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .result_valid_o    (result_valid_o),
    .kept_o            (kept_o),
    .table_overflow_o  (table_overflow_o)
  );

  // A result is shown only once the controller is free again.
  `ASSERT_CLK_RST(a_result_when_idle, clk_i, rst_ni, result_valid_o |-> !busy)
  // An overflow is only reported for a kept candidate.
  `ASSERT_CLK_RST(a_overflow_kept, clk_i, rst_ni,
                  (result_valid_o && table_overflow_o) |-> kept_o)
  // Each transaction gives a single one-cycle result strobe.
  `ASSERT_CLK_RST(a_single_strobe, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  // The controller issues at most one command per cycle.
  `ASSERT_CLK_RST(a_cmd_onehot, clk_i, rst_ni, $onehot0({cmd.load, cmd.issue, cmd.finish}))

endmodule
